// ----- rtl/aidf_pkg.sv -----
`timescale 1ns / 1ps
package aidf_pkg;

  localparam int DIMENSIONS_DEF = 3;
  localparam int FX_FRAC = 16;
  localparam logic signed [31:0] FX_ONE = 32'sh0001_0000;

  localparam int SQRT_STAGES = 16;
  localparam int DIV_STEPS = 17;
  localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;

  localparam int ST_SQ = 0;
  localparam int ST_SUM = 1;
  localparam int ST_SQRT = 2;
  localparam int ST_DIV = ST_SQRT + SQRT_STAGES;
  localparam int ST_NN = ST_DIV + DIV_STAGES;
  localparam int ST_PAR = ST_NN + 1;
  localparam int ST_T = ST_NN + 2;
  localparam int ST_TW = ST_NN + 3;
  localparam int ST_D = ST_NN + 4;
  localparam int ST_DPHI = ST_NN + 5;
  localparam int ST_E = ST_NN + 6;
  localparam int ST_EC = ST_NN + 7;
  localparam int ST_OUT = ST_NN + 8;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_PARALLEL   = 1'b0,
    REG_ORTHOGONAL = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] phi_one;
    logic signed [31:0] phi_two;
    logic signed [31:0] grad_one_x;
    logic signed [31:0] grad_one_y;
    logic signed [31:0] grad_one_z;
    logic signed [31:0] grad_two_x;
    logic signed [31:0] grad_two_y;
    logic signed [31:0] grad_two_z;
    logic signed [31:0] conc_grad_x;
    logic signed [31:0] conc_grad_y;
    logic signed [31:0] conc_grad_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] flux_x;
    logic signed [31:0] flux_y;
    logic signed [31:0] flux_z;
  } result_t;

  typedef struct packed {
    logic                   cmd;
    logic signed [31:0]     phi_one;
    logic signed [31:0]     phi_two;
    logic signed [31:0]     w;
    logic [2:0][31:0]       conc;
    logic [1:0][2:0][31:0]  g_abs;
    logic [1:0][2:0]        g_neg;
  } side_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [16:0] quo;
  } div_st_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7fff_ffff) begin
      return 32'sh7fff_ffff;
    end else if (v < 64'shffff_ffff_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // truncation toward zero, then saturate
  function automatic logic signed [31:0] fx_trunc(input logic signed [63:0] p);
    logic signed [63:0] adj;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    return sat32(adj >>> FX_FRAC);
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
    sqrt_st_t o;
    logic [34:0] cur;
    logic [34:0] trial;
    cur = {s.rem[32:0], s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (cur >= trial) begin
      o.rem = cur - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = cur;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_st_t div_step(input div_st_t s, input logic [31:0] d);
    div_st_t o;
    logic [32:0] r;
    logic b;
    b = (s.rem >= {1'b0, d});
    r = b ? (s.rem - {1'b0, d}) : s.rem;
    o.quo = {s.quo[15:0], b};
    o.rem = {r[31:0], 1'b0};
    return o;
  endfunction

endpackage

// ----- rtl/aidf_sqrt.sv -----
`timescale 1ns / 1ps
module aidf_sqrt (
  input  logic                              clk,
  input  logic [aidf_pkg::SQRT_STAGES-1:0] en,
  input  logic [63:0]                       rad,
  output logic [31:0]                       root
);
  import aidf_pkg::*;

  sqrt_st_t st   [SQRT_STAGES];
  sqrt_st_t prev [SQRT_STAGES];

  always_comb begin
    prev[0] = '{rad: rad, rem: '0, root: '0};
    for (int s = 1; s < SQRT_STAGES; s++) begin
      prev[s] = st[s-1];
    end
  end

  // two result bits per stage
  always_ff @(posedge clk) begin
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (en[s]) begin
        st[s] <= sqrt_step(sqrt_step(prev[s]));
      end
    end
  end

  assign root = st[SQRT_STAGES-1].root;

endmodule

// ----- rtl/aidf_div.sv -----
`timescale 1ns / 1ps
module aidf_div (
  input  logic                             clk,
  input  logic [aidf_pkg::DIV_STAGES-1:0] en,
  input  logic [31:0]                      mag,
  input  logic [31:0]                      g_abs,
  input  logic                             g_neg,
  output logic signed [17:0]               normal
);
  import aidf_pkg::*;

  typedef struct packed {
    div_st_t     st;
    logic [31:0] dvs;
    logic        neg;
    logic        zero;
  } div_pipe_t;

  div_pipe_t pipe [DIV_STAGES];
  div_pipe_t prev [DIV_STAGES];
  div_pipe_t nxt  [DIV_STAGES];

  always_comb begin
    prev[0].st.rem = {1'b0, g_abs};
    prev[0].st.quo = '0;
    prev[0].dvs = mag;
    prev[0].neg = g_neg;
    prev[0].zero = (mag == '0);
    for (int s = 1; s < DIV_STAGES; s++) begin
      prev[s] = pipe[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      nxt[s] = prev[s];
      nxt[s].st = div_step(prev[s].st, prev[s].dvs);
      if (2 * s + 1 < DIV_STEPS) begin
        nxt[s].st = div_step(nxt[s].st, prev[s].dvs);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[s]) begin
        pipe[s] <= nxt[s];
      end
    end
  end

  always_comb begin
    if (pipe[DIV_STAGES-1].zero) begin
      normal = '0;
    end else if (pipe[DIV_STAGES-1].neg) begin
      normal = -signed'({1'b0, pipe[DIV_STAGES-1].st.quo});
    end else begin
      normal = signed'({1'b0, pipe[DIV_STAGES-1].st.quo});
    end
  end

endmodule

// ----- rtl/anisotropic_interface_diffusion_flux.sv -----
`timescale 1ns / 1ps
// channel   | valid         | stall         | payload
// item      | item_valid    | item_stall    | item   (aidf_pkg::item_t)
// result    | result_valid  | result_stall  | result (aidf_pkg::result_t)
// config    | psel/penable  | pready (=1)   | paddr, pwdata, prdata
//
// one item per cycle sustained while result_stall is low
// most of the pipeline depth is in the 16-stage square root and 9-stage divider pipelines
// each stage holds its item while the next stage is full and stalled, so
// bubbles close up and a waiting result blocks new transfers only once every stage is full
// rst clears the valid bits and both coefficient registers
module anisotropic_interface_diffusion_flux #(
  parameter int DIMENSIONS = aidf_pkg::DIMENSIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  aidf_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output aidf_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aidf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import aidf_pkg::*;

  logic signed [31:0] par;
  logic signed [31:0] orth;

  always_ff @(posedge clk) begin
    if (rst) begin
      par <= '0;
      orth <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel_t'(paddr[2]))
        REG_PARALLEL:   par <= pwdata;
        REG_ORTHOGONAL: orth <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel_t'(paddr[2]))
      REG_PARALLEL:   prdata = par;
      REG_ORTHOGONAL: prdata = orth;
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // pipeline control
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] vld_in;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !result_stall;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign vld_in = {vld[NUM_STAGES-2:0], item_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          vld[s] <= vld_in[s];
        end
      end
    end
  end

  assign item_stall = !en[0];
  assign result_valid = vld[NUM_STAGES-1];

  // input unpack with unused dimensions masked
  logic signed [31:0] g_in [2][3];
  logic signed [31:0] c_in [3];
  side_t              side_in;

  always_comb begin
    g_in[0][0] = item.grad_one_x;
    g_in[0][1] = item.grad_one_y;
    g_in[0][2] = item.grad_one_z;
    g_in[1][0] = item.grad_two_x;
    g_in[1][1] = item.grad_two_y;
    g_in[1][2] = item.grad_two_z;
    c_in[0] = item.conc_grad_x;
    c_in[1] = item.conc_grad_y;
    c_in[2] = item.conc_grad_z;
    side_in.cmd = item.cmd;
    side_in.phi_one = item.phi_one;
    side_in.phi_two = item.phi_two;
    side_in.w = '0;
    for (int i = 0; i < 3; i++) begin
      side_in.conc[i] = (i < DIMENSIONS) ? c_in[i] : '0;
      for (int k = 0; k < 2; k++) begin
        if (i < DIMENSIONS) begin
          side_in.g_abs[k][i] = g_in[k][i][31] ? -g_in[k][i] : g_in[k][i];
          side_in.g_neg[k][i] = g_in[k][i][31];
        end else begin
          side_in.g_abs[k][i] = '0;
          side_in.g_neg[k][i] = 1'b0;
        end
      end
    end
  end

  // side data travels with the item
  side_t side      [ST_OUT];
  side_t side_prev [ST_OUT];

  logic [63:0]        sq [2][3];
  logic signed [63:0] p_phi;
  logic [63:0]        sum [2];
  logic signed [31:0] w_calc;

  assign w_calc = sat32(64'(fx_trunc(p_phi)) <<< 2);

  always_comb begin
    side_prev[0] = side_in;
    for (int s = 1; s < ST_OUT; s++) begin
      side_prev[s] = side[s-1];
    end
    side_prev[ST_SUM].w = w_calc;
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ST_OUT; s++) begin
      if (en[s]) begin
        side[s] <= side_prev[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          sq[k][i] <= side_in.g_abs[k][i] * side_in.g_abs[k][i];
        end
      end
      p_phi <= fx_mul(item.phi_one, item.phi_two);
    end
    if (en[ST_SUM]) begin
      for (int k = 0; k < 2; k++) begin
        sum[k] <= sq[k][0] + sq[k][1] + sq[k][2];
      end
    end
  end

  // gradient magnitude and unit normal
  logic [31:0]        mag    [2];
  logic signed [17:0] normal [2][3];

  for (genvar k = 0; k < 2; k++) begin : g_grad
    aidf_sqrt u_sqrt (
      .clk  (clk),
      .en   (en[ST_SQRT +: SQRT_STAGES]),
      .rad  (sum[k]),
      .root (mag[k])
    );
    for (genvar i = 0; i < 3; i++) begin : g_comp
      aidf_div u_div (
        .clk    (clk),
        .en     (en[ST_DIV +: DIV_STAGES]),
        .mag    (mag[k]),
        .g_abs  (side[ST_DIV-1].g_abs[k][i]),
        .g_neg  (side[ST_DIV-1].g_neg[k][i]),
        .normal (normal[k][i])
      );
    end
  end

  // tensor and flux
  logic signed [63:0] p_nn   [2][3][3];
  logic signed [63:0] p_par  [2][3][3];
  logic signed [63:0] p_orth [2][3][3];
  logic signed [31:0] t_val  [2][3][3];
  logic signed [63:0] p_tw   [2][3][3];
  logic signed [31:0] d_val  [2][3][3];
  logic signed [63:0] p_d    [2][3][3];
  logic signed [31:0] e_val  [3][3];
  logic signed [63:0] p_ec   [3][3];
  logic signed [31:0] flux   [3];
  logic signed [31:0] acc_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sat[i] = sat32(64'(fx_trunc(p_ec[i][0])) + 64'(fx_trunc(p_ec[i][1]))
                         + 64'(fx_trunc(p_ec[i][2])));
      if (!side[ST_OUT-1].cmd) begin
        flux[i] = sat32(-64'(acc_sat[i]));
      end else begin
        flux[i] = acc_sat[i];
      end
      if (i >= DIMENSIONS) begin
        flux[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (en[ST_NN]) begin
            p_nn[k][i][j] <= fx_mul(32'(normal[k][i]), 32'(normal[k][j]));
          end
          if (en[ST_PAR]) begin
            p_par[k][i][j] <= fx_mul(par, sat32(64'((i == j) ? FX_ONE : 32'sd0)
                                                - 64'(fx_trunc(p_nn[k][i][j]))));
            p_orth[k][i][j] <= fx_mul(orth, fx_trunc(p_nn[k][i][j]));
          end
          if (en[ST_T]) begin
            t_val[k][i][j] <= sat32(64'(fx_trunc(p_par[k][i][j]))
                                    + 64'(fx_trunc(p_orth[k][i][j])));
          end
          if (en[ST_TW]) begin
            p_tw[k][i][j] <= fx_mul(t_val[k][i][j], side[ST_TW-1].w);
          end
          if (en[ST_D]) begin
            d_val[k][i][j] <= sat32(64'((i == j) ? FX_ONE : 32'sd0)
                                    - 64'(fx_trunc(p_tw[k][i][j])));
          end
          if (en[ST_DPHI]) begin
            p_d[k][i][j] <= fx_mul(d_val[k][i][j],
                                   (k == 0) ? side[ST_DPHI-1].phi_one
                                            : side[ST_DPHI-1].phi_two);
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (en[ST_E]) begin
          e_val[i][j] <= sat32(64'(fx_trunc(p_d[0][i][j])) + 64'(fx_trunc(p_d[1][i][j])));
        end
        if (en[ST_EC]) begin
          p_ec[i][j] <= fx_mul(e_val[i][j], signed'(side[ST_EC-1].conc[j]));
        end
      end
    end
    if (en[ST_OUT]) begin
      result.flux_x <= flux[0];
      result.flux_y <= flux[1];
      result.flux_z <= flux[2];
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import aidf_pkg::*;

  localparam int LATENCY = 36;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic CMD_NEGATED = 1'b0;
  localparam logic CMD_FLUX = 1'b1;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  anisotropic_interface_diffusion_flux dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic signed [63:0] par_coeff;
  logic signed [63:0] orth_coeff;
  result_t flux_expected[$];
  int mismatches;
  int idle_cycles;
  bit timed_out;
  bit gaps_on;
  int gap_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [63:0] sat(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    return sat((a * b) / 64'sd65536);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  typedef logic signed [63:0] vec3_t[3];

  function automatic vec3_t normal_of(input vec3_t g);
    vec3_t n;
    logic [63:0] acc, a;
    logic signed [63:0] mag;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = 0;
      a = g[i] < 0 ? -g[i] : g[i];
      acc += a * a;
    end
    mag = root64(acc);
    if (mag != 0)
      for (int i = 0; i < 3; i++) n[i] = sat((g[i] * 64'sd65536) / mag);
    return n;
  endfunction

  function automatic logic signed [63:0] diff_entry(input vec3_t n, input int i,
      input int j, input logic signed [63:0] w);
    logic signed [63:0] delta, nn, tang, t;
    delta = (i == j) ? 64'sd65536 : 64'sd0;
    nn = qmul(n[i], n[j]);
    tang = sat(delta - nn);
    t = sat(qmul(par_coeff, tang) + qmul(orth_coeff, nn));
    return sat(delta - qmul(t, w));
  endfunction

  function automatic result_t predict_flux(input item_t it);
    vec3_t g1, g2, c, n1, n2;
    logic signed [63:0] p1, p2, w, acc, e;
    logic signed [31:0] f[3];
    result_t r;
    p1 = it.phi_one;
    p2 = it.phi_two;
    g1 = '{it.grad_one_x, it.grad_one_y, it.grad_one_z};
    g2 = '{it.grad_two_x, it.grad_two_y, it.grad_two_z};
    c = '{it.conc_grad_x, it.conc_grad_y, it.conc_grad_z};
    n1 = normal_of(g1);
    n2 = normal_of(g2);
    w = sat(4 * qmul(p1, p2));
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        e = sat(qmul(diff_entry(n1, i, j, w), p1) + qmul(diff_entry(n2, i, j, w), p2));
        acc += qmul(e, c[j]);
      end
      acc = sat(acc);
      if (it.cmd == CMD_NEGATED) acc = sat(-acc);
      f[i] = acc[31:0];
    end
    r.flux_x = f[0];
    r.flux_y = f[1];
    r.flux_z = f[2];
    return r;
  endfunction

  task automatic write_coeff(input reg_sel_t sel, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'(4 * int'(sel));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PARALLEL) par_coeff = $signed(value);
    else orth_coeff = $signed(value);
  endtask

  task automatic send_item(input item_t it);
    while (gaps_on && $urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    flux_expected.push_back(predict_flux(it));
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (flux_expected.size() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(3);
      3: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.cmd = 1'($urandom_range(1));
    it.phi_one = rand_word();
    it.phi_two = rand_word();
    it.grad_one_x = rand_word();
    it.grad_one_y = rand_word();
    it.grad_one_z = rand_word();
    it.grad_two_x = rand_word();
    it.grad_two_y = rand_word();
    it.grad_two_z = rand_word();
    it.conc_grad_x = rand_word();
    it.conc_grad_y = rand_word();
    it.conc_grad_z = rand_word();
    if ($urandom_range(4) == 0) begin
      it.grad_one_x = 0; it.grad_one_y = 0; it.grad_one_z = 0;
    end
    if ($urandom_range(4) == 0) begin
      it.grad_two_x = 0; it.grad_two_y = 0; it.grad_two_z = 0;
    end
    return it;
  endfunction

  function automatic item_t fill_item(input logic cmd, input logic [31:0] v);
    item_t it;
    it = {cmd, {11{v}}};
    return it;
  endfunction

  task automatic test_directed;
    item_t it;
    write_coeff(REG_PARALLEL, 32'h0000_8000);
    write_coeff(REG_ORTHOGONAL, 32'h0001_0000);
    send_item(fill_item(CMD_FLUX, 32'h0));
    send_item(fill_item(CMD_NEGATED, 32'h0001_0000));
    send_item(fill_item(CMD_FLUX, 32'h7fff_ffff));
    send_item(fill_item(CMD_NEGATED, 32'h8000_0000));
    send_item(fill_item(CMD_FLUX, 32'hffff_ffff));
    send_item(fill_item(CMD_NEGATED, 32'h5555_5555));
    send_item(fill_item(CMD_FLUX, 32'haaaa_aaaa));
    // zero gradients, unit inputs
    it = fill_item(CMD_FLUX, 32'h0001_0000);
    it.grad_one_x = 0; it.grad_one_y = 0; it.grad_one_z = 0;
    send_item(it);
    it.grad_two_x = 0; it.grad_two_y = 0; it.grad_two_z = 0;
    send_item(it);
    // negation of the most negative flux
    it = fill_item(CMD_NEGATED, 32'h0);
    it.phi_one = 32'h7fff_ffff;
    it.conc_grad_x = 32'h8000_0000;
    send_item(it);
    it.cmd = CMD_FLUX;
    send_item(it);
    it = fill_item(CMD_FLUX, 32'h0000_8000);
    it.grad_one_y = 32'h0;
    it.grad_two_x = 32'hffff_0000;
    send_item(it);
    drain();
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++) begin
      gaps_on = !(k >= count / 3 && k < count / 2);
      send_item(random_item());
    end
    gaps_on = 1'b1;
    drain();
  endtask

  task automatic test_coefficients;
    logic [31:0] sets[5][2];
    sets = '{'{32'h8000_0000, 32'h7fff_ffff}, '{32'h7fff_ffff, 32'h8000_0000},
             '{32'h0, 32'h0}, '{32'hffff_0000, 32'h0002_0000}, '{32'h0, 32'h0}};
    for (int s = 0; s < 5; s++) begin
      if (s == 4) begin
        sets[s][0] = $urandom;
        sets[s][1] = $urandom;
      end
      write_coeff(REG_PARALLEL, sets[s][0]);
      write_coeff(REG_ORTHOGONAL, sets[s][1]);
      test_random(190);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= gaps_on && ($urandom_range(99) < gap_pct);
      if (result_valid && !result_stall) begin
        if (flux_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          result_t exp_r;
          exp_r = flux_expected.pop_front();
          if (exp_r.flux_x !== result.flux_x || exp_r.flux_y !== result.flux_y ||
              exp_r.flux_z !== result.flux_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("flux mismatch: expected %h %h %h got %h %h %h",
                       exp_r.flux_x, exp_r.flux_y, exp_r.flux_z,
                       result.flux_x, result.flux_y, result.flux_z);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    par_coeff = 0;
    orth_coeff = 0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    gaps_on = 1'b1;
    gap_pct = 29;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_coefficients();
    if (mismatches == 0 && flux_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
